// ===== sv/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

  // Command codes carried in req_type.
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RECV  = 3'd3,
    CMD_SACK  = 3'd4,
    CMD_RACK  = 3'd5
  } cmd_t;

  localparam logic [2:0] CMD_COUNT = 3'd6;

  // Bit position that closes a byte command.
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_ack;
    logic       busy_res;
    logic       cmd_dropped;
  } out_t;

  // Final phase of one bit (or of the whole sequence for non-byte commands).
  function automatic logic [1:0] last_phase(input cmd_t cmd);
    logic [1:0] lp;
    unique case (cmd)
      CMD_START: lp = 2'd3;
      CMD_STOP:  lp = 2'd2;
      CMD_SEND:  lp = 2'd2;
      CMD_RECV:  lp = 2'd3;
      CMD_SACK:  lp = 2'd2;
      CMD_RACK:  lp = 2'd3;
      default:   lp = 2'd3;
    endcase
    return lp;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2c_master_bit_engine_unit.sv =====
`default_nettype none

// I2C master bit engine. Each request on the in_ channel is one bus delay slot
// and carries the sampled SDA level plus, optionally, a new command; each
// request yields exactly one result on the out_ channel with the SCL/SDA drive
// levels after that slot (1 released, 0 pulled low), a done flag in the final
// slot of a command, the last received byte and acknowledge, a busy flag and a
// flag for a command offered while busy. The block takes one request per clock
// cycle while results are taken and returns each result in the next cycle: the
// slot update is a single pass of logic into the result register, and in_ready
// stays high whenever that register is empty or being taken in the same cycle.
// Commands run one at a time: start 4 slots, stop 3, send byte 24, receive byte 32, send ack 3,
// receive ack 4. Codes 6 and 7 are ignored while idle.
module i2c_master_bit_engine_unit (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  i2cm_pkg::in_t    in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output i2cm_pkg::out_t   out_data
);
  import i2cm_pkg::*;

  // Engine state.
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       run_r, run_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       ack_lvl_r, ack_lvl_nxt;
  logic       rx_ack_r, rx_ack_nxt;
  logic [7:0] rx_hold_r, rx_hold_nxt;

  // Result register.
  logic       out_valid_r;
  out_t       out_data_r, out_data_nxt;

  logic       accept;
  logic       done;
  logic       dropped;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One slot of the sequencer.
  always_comb begin
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    run_nxt     = run_r;
    cmd_nxt     = cmd_r;
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    ack_lvl_nxt = ack_lvl_r;
    rx_ack_nxt  = rx_ack_r;
    rx_hold_nxt = rx_hold_r;
    done        = 1'b0;
    dropped     = 1'b0;

    // Take a new command only when idle; flag any offer made while busy.
    if (run_r) begin
      dropped = in_data.cmd_valid;
    end else if (in_data.cmd_valid && (in_data.req_type < CMD_COUNT)) begin
      run_nxt   = 1'b1;
      cmd_nxt   = cmd_t'(in_data.req_type);
      phase_nxt = 2'd0;
      bit_nxt   = 3'd0;
      if (cmd_t'(in_data.req_type) == CMD_SEND) begin
        shift_nxt = in_data.tx_byte;
      end else if (cmd_t'(in_data.req_type) == CMD_RECV) begin
        shift_nxt = 8'd0;
      end else if (cmd_t'(in_data.req_type) == CMD_SACK) begin
        ack_lvl_nxt = in_data.ack_out;
      end
    end

    if (run_nxt) begin
      unique case (cmd_nxt)
        CMD_START: begin
          unique case (phase_nxt)
            2'd0:    scl_nxt = 1'b1;
            2'd1:    sda_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        CMD_STOP: begin
          unique case (phase_nxt)
            2'd0:    sda_nxt = 1'b0;
            2'd1:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        CMD_SEND: begin
          unique case (phase_nxt)
            2'd0:    sda_nxt = shift_nxt[~bit_nxt];
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        CMD_RECV: begin
          unique case (phase_nxt)
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    shift_nxt[~bit_nxt] = in_data.sda_in;
            default: scl_nxt = 1'b0;
          endcase
        end
        CMD_SACK: begin
          unique case (phase_nxt)
            2'd0:    sda_nxt = ack_lvl_nxt;
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        default: begin
          unique case (phase_nxt)
            2'd0:    sda_nxt    = 1'b1;
            2'd1:    scl_nxt    = 1'b1;
            2'd2:    rx_ack_nxt = in_data.sda_in;
            default: scl_nxt    = 1'b0;
          endcase
        end
      endcase

      // Advance phase, then bit; byte commands finish on their last bit.
      if (phase_nxt == last_phase(cmd_nxt)) begin
        if (((cmd_nxt != CMD_SEND) && (cmd_nxt != CMD_RECV)) || (bit_nxt == LAST_BIT)) begin
          done      = 1'b1;
          run_nxt   = 1'b0;
          phase_nxt = 2'd0;
          bit_nxt   = 3'd0;
          if (cmd_nxt == CMD_RECV) begin
            rx_hold_nxt = shift_nxt;
          end
        end else begin
          phase_nxt = 2'd0;
          bit_nxt   = bit_nxt + 3'd1;
        end
      end else begin
        phase_nxt = phase_nxt + 2'd1;
      end
    end
  end

  always_comb begin
    out_data_nxt.scl_out     = scl_nxt;
    out_data_nxt.sda_out     = sda_nxt;
    out_data_nxt.done_res    = done;
    out_data_nxt.rx_byte     = rx_hold_nxt;
    out_data_nxt.rx_ack      = rx_ack_nxt;
    out_data_nxt.busy_res    = run_nxt;
    out_data_nxt.cmd_dropped = dropped;
  end

  // Commit the slot on every accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      run_r     <= 1'b0;
      cmd_r     <= CMD_START;
      phase_r   <= 2'd0;
      bit_r     <= 3'd0;
      shift_r   <= 8'd0;
      ack_lvl_r <= 1'b0;
      rx_ack_r  <= 1'b1;
      rx_hold_r <= 8'd0;
    end else if (accept) begin
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      run_r     <= run_nxt;
      cmd_r     <= cmd_nxt;
      phase_r   <= phase_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      ack_lvl_r <= ack_lvl_nxt;
      rx_ack_r  <= rx_ack_nxt;
      rx_hold_r <= rx_hold_nxt;
    end
  end

  // Hold the result until taken; refill in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cm_checker.sv =====
`default_nettype none

module i2cm_checker (
  input wire             clk,
  input wire             rst_n,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input i2cm_pkg::out_t  out_data
);
  import i2cm_pkg::*;

  // Result register starts empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An empty result register never blocks a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty result register");

  // The final slot of a command leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done and busy together");

  // A dropped command means one was running through that slot.
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmd_dropped |-> out_data.busy_res || out_data.done_res)
    else $error("command dropped while idle");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import i2cm_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  // Request side: one request is one bus delay slot.
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;

  // Result side: one result per slot.
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  i2c_master_bit_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Slot requests waiting to go out, and bus states still owed by the block.
  in_t  slot_requests[$];
  out_t bus_forecast[$];
  int   fault_count = 0;

  // Engine shadow state, starting at the reset values.
  logic       line_scl    = 1'b1;
  logic       line_sda    = 1'b1;
  logic       engine_busy = 1'b0;
  cmd_t       active_cmd  = CMD_START;
  int         slot_no     = 0;
  logic [7:0] shift_reg   = '0;
  logic       ack_drive   = 1'b0;
  logic       ack_seen    = 1'b1;
  logic [7:0] byte_seen   = '0;

  // Number of bus slots each command occupies.
  function automatic int slot_count(input cmd_t cmd);
    case (cmd)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_SEND:  return 24;
      CMD_RECV:  return 32;
      CMD_SACK:  return 3;
      default:   return 4;
    endcase
  endfunction

  // Advance the shadow engine by one slot and produce the bus state it leaves.
  task automatic advance_engine(input in_t req, output out_t res);
    int   bit_no;
    int   phase;
    logic dropped;
    logic done;
    dropped = 1'b0;
    done    = 1'b0;
    // A busy engine ignores any offer, even in its final slot; an idle one
    // takes a known code and runs its first slot right away.
    if (engine_busy) begin
      dropped = req.cmd_valid;
    end else if (req.cmd_valid && req.req_type < CMD_COUNT) begin
      engine_busy = 1'b1;
      active_cmd  = cmd_t'(req.req_type);
      slot_no     = 0;
      case (active_cmd)
        CMD_SEND: shift_reg = req.tx_byte;
        CMD_RECV: shift_reg = '0;
        CMD_SACK: ack_drive = req.ack_out;
        default: ;
      endcase
    end
    if (engine_busy) begin
      case (active_cmd)
        CMD_START: begin
          case (slot_no)
            0: line_scl = 1'b1;
            1: line_sda = 1'b1;
            2: line_sda = 1'b0;
            default: line_scl = 1'b0;
          endcase
        end
        CMD_STOP: begin
          case (slot_no)
            0: line_sda = 1'b0;
            1: line_scl = 1'b1;
            default: line_sda = 1'b1;
          endcase
        end
        CMD_SEND: begin
          bit_no = slot_no / 3;
          phase  = slot_no % 3;
          case (phase)
            0: line_sda = shift_reg[7 - bit_no];
            1: line_scl = 1'b1;
            default: line_scl = 1'b0;
          endcase
        end
        CMD_RECV: begin
          // The sampling slot leaves both lines alone.
          bit_no = slot_no / 4;
          phase  = slot_no % 4;
          case (phase)
            0: line_sda = 1'b1;
            1: line_scl = 1'b1;
            2: if (req.sda_in) shift_reg[7 - bit_no] = 1'b1;
            default: line_scl = 1'b0;
          endcase
        end
        CMD_SACK: begin
          case (slot_no)
            0: line_sda = ack_drive;
            1: line_scl = 1'b1;
            default: line_scl = 1'b0;
          endcase
        end
        default: begin
          case (slot_no)
            0: line_sda = 1'b1;
            1: line_scl = 1'b1;
            2: ack_seen = req.sda_in;
            default: line_scl = 1'b0;
          endcase
        end
      endcase
      if (slot_no + 1 >= slot_count(active_cmd)) begin
        // Publish the received byte only in the final slot of the receive.
        done        = 1'b1;
        engine_busy = 1'b0;
        slot_no     = 0;
        if (active_cmd == CMD_RECV) byte_seen = shift_reg;
      end else begin
        slot_no++;
      end
    end
    res.scl_out     = line_scl;
    res.sda_out     = line_sda;
    res.done_res    = done;
    res.rx_byte     = byte_seen;
    res.rx_ack      = ack_seen;
    res.busy_res    = engine_busy;
    res.cmd_dropped = dropped;
  endtask

  // Random slot with no command offered; every other field is noise.
  function automatic in_t random_slot();
    in_t item;
    item.cmd_valid = 1'b0;
    item.req_type  = 3'($urandom_range(0, 7));
    item.tx_byte   = 8'($urandom_range(0, 255));
    item.ack_out   = 1'($urandom_range(0, 1));
    item.sda_in    = 1'($urandom_range(0, 1));
    return item;
  endfunction

  // Queue one command and the slots it runs for. sda_mode picks the SDA
  // level the slave shows: 0 low, 1 high, anything else random.
  // busy_pct is the chance of a stray offer in each later slot.
  task automatic queue_command(input logic [2:0] code, input logic [7:0] txb,
                               input logic ackv, input int sda_mode,
                               input int busy_pct, input bit offer_last);
    in_t item;
    int  n;
    n = (code < CMD_COUNT) ? slot_count(cmd_t'(code)) : 1;
    for (int i = 0; i < n; i++) begin
      item = random_slot();
      if (sda_mode == 0) item.sda_in = 1'b0;
      else if (sda_mode == 1) item.sda_in = 1'b1;
      if (i == 0) begin
        item.cmd_valid = 1'b1;
        item.req_type  = code;
        item.tx_byte   = txb;
        item.ack_out   = ackv;
      end else begin
        item.cmd_valid = (offer_last && i == n - 1) ||
                         ($urandom_range(0, 99) < busy_pct);
      end
      slot_requests.push_back(item);
    end
  endtask

  // Draw the wait before the next handshake; flip into or out of a calm
  // stretch with no waits now and then.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      fault_count++;
    end
  endtask

  // Handshakes complete at the rising edge. Check the result first, then
  // predict for the slot just taken.
  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;

  always @(posedge clk) begin
    out_t want;
    out_t got;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    got = out_data;
    if (out_fire) begin
      if (bus_forecast.size() == 0) begin
        $error("result with no request outstanding");
        fault_count++;
      end else begin
        want = bus_forecast.pop_front();
        check_field("scl_out", want.scl_out, got.scl_out);
        check_field("sda_out", want.sda_out, got.sda_out);
        check_field("done_res", want.done_res, got.done_res);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("rx_ack", want.rx_ack, got.rx_ack);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("cmd_dropped", want.cmd_dropped, got.cmd_dropped);
      end
    end
    if (in_fire) begin
      advance_engine(in_data, want);
      bus_forecast.push_back(want);
    end
  end

  // Request driver: hold a request until it is taken, then wait out the
  // drawn gap before offering the next one.
  int in_gap  = 0;
  bit in_calm = 1'b0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (slot_requests.size() > 0) begin
        in_data  <= slot_requests.pop_front();
        in_valid <= 1'b1;
        in_gap   = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result acceptor: after each taken result, stall for a drawn number of
  // cycles before raising ready again.
  int out_hold = 0;
  bit out_calm = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_hold = draw_wait(out_calm);
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int pick;

    // Directed: idle slots, unknown codes while idle, every command with
    // extreme data, offers while busy including the final slot, and
    // receives that see all-low and all-high SDA.
    slot_requests.push_back(random_slot());
    slot_requests.push_back(random_slot());
    queue_command(3'd6, 8'h00, 1'b0, 2, 0, 1'b0);
    queue_command(3'd7, 8'hFF, 1'b1, 2, 0, 1'b0);
    queue_command(CMD_START, 8'h00, 1'b0, 2, 0, 1'b0);
    queue_command(CMD_SEND, 8'hFF, 1'b1, 2, 0, 1'b0);
    queue_command(CMD_SEND, 8'h00, 1'b0, 2, 0, 1'b1);
    queue_command(CMD_SEND, 8'hA5, 1'b0, 2, 30, 1'b0);
    queue_command(CMD_RACK, 8'h00, 1'b0, 0, 0, 1'b0);
    queue_command(CMD_RECV, 8'h00, 1'b0, 1, 0, 1'b0);
    queue_command(CMD_SACK, 8'h00, 1'b0, 2, 0, 1'b1);
    queue_command(CMD_RECV, 8'hFF, 1'b1, 0, 20, 1'b0);
    queue_command(CMD_SACK, 8'hFF, 1'b1, 2, 0, 1'b0);
    queue_command(CMD_RACK, 8'hFF, 1'b1, 1, 0, 1'b1);
    queue_command(CMD_STOP, 8'h00, 1'b0, 2, 0, 1'b0);

    // Random: mostly whole commands with random content, some with stray
    // offers, plus unknown codes and bare idle slots as noise.
    while (slot_requests.size() < 900) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        queue_command(3'($urandom_range(0, 5)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 2,
                      ($urandom_range(0, 3) == 0) ? 20 : 0,
                      $urandom_range(0, 7) == 0);
      end else if (pick < 88) begin
        queue_command(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 2, 0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) slot_requests.push_back(random_slot());
      end
    end

    // Release reset at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Drain: everything sent and every owed result seen, then let a few
    // more cycles pass to catch stray results.
    while (slot_requests.size() > 0 || in_valid || bus_forecast.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);

    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/i2cm_pkg.sv
sv/i2c_master_bit_engine_unit.sv
sv/i2cm_checker.sv
bench/tb_top.sv
